// ===== hdl/gnp_pkg.sv =====
// ----------------------------------------------------------------------------
// gnp_pkg
// Shared types, codes and arithmetic helpers of the gradient noise pixel core.
// ----------------------------------------------------------------------------
package gnp_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam int REG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;
  localparam logic [REG_INDEX_W-1:0] REG_GRID_SIZE = 1'b0;
  localparam logic [REG_INDEX_W-1:0] REG_TILE_RES  = 1'b1;

  localparam logic [4:0] GRID_SIZE_RESET = 5'd16;
  localparam logic [8:0] TILE_RES_RESET  = 9'd16;

  localparam int TABLE_AW = 8;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int COORD_W = 12;
  localparam int FRAC_W = 16;

  localparam logic signed [17:0] ONE_Q16  = 18'sd65536;
  localparam logic signed [40:0] HALF_Q30 = 41'sd536870912;
  localparam logic [17:0] THREE_Q16 = 18'd196608;

  typedef struct packed {
    logic                      command;
    logic [TABLE_AW-1:0]       grid_index;
    logic signed [15:0]        grad_x;
    logic signed [15:0]        grad_y;
    logic [COORD_W-1:0]        pixel_x;
    logic [COORD_W-1:0]        pixel_y;
  } pixel_req_t;

  typedef struct packed {
    logic [15:0] noise_value;
    logic        coord_error;
  } pixel_rsp_t;

  typedef struct packed {
    logic                cmd;
    logic [TABLE_AW-1:0] idx;
    logic signed [15:0]  gx;
    logic signed [15:0]  gy;
    logic                err;
  } item_t;

  typedef struct packed {
    item_t              item;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } cell_t;

  // gradient entry dot offset, exact q.30
  function automatic logic signed [34:0] corner_dot(input logic [31:0] e,
                                                    input logic signed [17:0] ox,
                                                    input logic signed [17:0] oy);
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [34:0] px;
    logic signed [34:0] py;
    gx = e[15:0];
    gy = e[31:16];
    px = gx * ox;
    py = gy * oy;
    return px + py;
  endfunction

endpackage

// ===== hdl/gnp_stream_if.sv =====
// ----------------------------------------------------------------------------
// gnp_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface gnp_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/gnp_divider.sv =====
// ----------------------------------------------------------------------------
// gnp_divider
// Two-lane pipelined restoring divider, one quotient bit per stage, with a
// sideband bus that travels alongside.
// ----------------------------------------------------------------------------
module gnp_divider #(
  parameter int NB = 12,
  parameter int DW = 9,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [SW-1:0] side_in,
  input  logic [DW-1:0] rem_x_in,
  input  logic [DW-1:0] rem_y_in,
  input  logic [NB-1:0] num_x_in,
  input  logic [NB-1:0] num_y_in,
  input  logic [DW-1:0] div,
  output logic          out_valid,
  output logic [SW-1:0] side_out,
  output logic [NB-1:0] quo_x,
  output logic [NB-1:0] quo_y,
  output logic [DW-1:0] rem_x,
  output logic [DW-1:0] rem_y
);

  logic          vld [NB+1];
  logic [SW-1:0] sd  [NB+1];
  logic [DW-1:0] rxs [NB+1];
  logic [DW-1:0] rys [NB+1];
  logic [NB-1:0] nxs [NB+1];
  logic [NB-1:0] nys [NB+1];
  logic [NB-1:0] qxs [NB+1];
  logic [NB-1:0] qys [NB+1];

  assign vld[0] = in_valid;
  assign sd[0]  = side_in;
  assign rxs[0] = rem_x_in;
  assign rys[0] = rem_y_in;
  assign nxs[0] = num_x_in;
  assign nys[0] = num_y_in;
  assign qxs[0] = '0;
  assign qys[0] = '0;

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [DW:0]   tx;
    logic [DW:0]   ty;
    logic          gex;
    logic          gey;
    logic [NB-1:0] qx_next;
    logic [NB-1:0] qy_next;

    assign tx  = {rxs[k], nxs[k][NB-1-k]};
    assign ty  = {rys[k], nys[k][NB-1-k]};
    assign gex = tx >= {1'b0, div};
    assign gey = ty >= {1'b0, div};

    always_comb begin
      qx_next = qxs[k];
      qy_next = qys[k];
      qx_next[NB-1-k] = gex;
      qy_next[NB-1-k] = gey;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1]  <= sd[k];
        nxs[k+1] <= nxs[k];
        nys[k+1] <= nys[k];
        rxs[k+1] <= gex ? DW'(tx - {1'b0, div}) : DW'(tx);
        rys[k+1] <= gey ? DW'(ty - {1'b0, div}) : DW'(ty);
        qxs[k+1] <= qx_next;
        qys[k+1] <= qy_next;
      end
    end
  end

  assign out_valid = vld[NB];
  assign side_out  = sd[NB];
  assign quo_x     = qxs[NB];
  assign quo_y     = qys[NB];
  assign rem_x     = rxs[NB];
  assign rem_y     = rys[NB];

endmodule

// ===== hdl/gradient_noise_pixel_core.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_pixel_core
// Two-dimensional gradient noise evaluated from a loaded gradient grid.
//
// req carries load and pixel transactions; a load writes one gradient entry
// and returns nothing, a pixel returns one transaction on rsp holding the
// noise value and the outside-grid flag. grid_size and tile_res are to be
// written by the user on the wr_en/wr_index/wr_data port only while no
// transaction is in flight; the core does not enforce this. The datapath is
// one pipeline: input register, range check, 12 stages of cell division,
// 16 stages of fraction division, address, table read, corner dots, and two
// blend levels of two stages each, the last one being the output register.
// While rsp is not stalled a new transaction is accepted every cycle; the
// four corner reads come from four copies of the gradient table, each with
// one read port.
// When rsp is stalled the whole pipeline holds and req.ready drops; nothing
// is lost or repeated. Reset clears the valid bits and sets grid_size and
// tile_res to 16; the gradient table is not cleared and must be loaded.
// ----------------------------------------------------------------------------
module gradient_noise_pixel_core #(
  parameter int GRID_MAX = 16,
  parameter int TILE_MAX = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [gnp_pkg::REG_INDEX_W-1:0]      wr_index,
  input  logic [gnp_pkg::CFG_DATA_W-1:0]       wr_data,
  gnp_stream_if.sink                           req,
  gnp_stream_if.source                         rsp
);
  import gnp_pkg::*;

  localparam int GW = $clog2(GRID_MAX + 1);
  localparam int TW = $clog2(TILE_MAX + 1);
  localparam int CW = (GW + TW > COORD_W) ? GW + TW : COORD_W;

  // configuration
  logic [4:0] cfg_grid;
  logic [8:0] cfg_tile;
  logic [GW-1:0] g_used;
  logic [TW-1:0] t_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_grid <= GRID_SIZE_RESET;
      cfg_tile <= TILE_RES_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GRID_SIZE: cfg_grid <= wr_data[4:0];
        REG_TILE_RES:  cfg_tile <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cfg_grid < 5'd2) begin
      g_used = GW'(2);
    end else if (int'(cfg_grid) > GRID_MAX) begin
      g_used = GW'(GRID_MAX);
    end else begin
      g_used = GW'(cfg_grid);
    end
    priority if (cfg_tile == '0) begin
      t_used = TW'(1);
    end else if (int'(cfg_tile) > TILE_MAX) begin
      t_used = TW'(TILE_MAX);
    end else begin
      t_used = TW'(cfg_tile);
    end
  end

  logic en;
  logic out_valid;
  pixel_rsp_t out_data;

  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;

  // input register
  logic               s0_valid;
  pixel_req_t         s0_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_req <= req.payload;
    end
  end

  // range check
  logic [GW+TW-1:0]   lim;
  logic [GW-1:0]      g_m1;
  logic               s1_valid;
  item_t              s1_item;
  logic [COORD_W-1:0] s1_px;
  logic [COORD_W-1:0] s1_py;

  assign g_m1 = g_used - GW'(1);
  assign lim  = g_m1 * t_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item.cmd <= s0_req.command;
      s1_item.idx <= s0_req.grid_index;
      s1_item.gx  <= s0_req.grad_x;
      s1_item.gy  <= s0_req.grad_y;
      s1_item.err <= (CW'(s0_req.pixel_x) >= CW'(lim)) || (CW'(s0_req.pixel_y) >= CW'(lim));
      s1_px       <= s0_req.pixel_x;
      s1_py       <= s0_req.pixel_y;
    end
  end

  // cell index and position within the cell
  logic               d1_valid;
  item_t              d1_item;
  logic [COORD_W-1:0] d1_cx;
  logic [COORD_W-1:0] d1_cy;
  logic [TW-1:0]      d1_rx;
  logic [TW-1:0]      d1_ry;

  gnp_divider #(.NB(COORD_W), .DW(TW), .SW($bits(item_t))) u_cell_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .side_in   (s1_item),
    .rem_x_in  ('0),
    .rem_y_in  ('0),
    .num_x_in  (s1_px),
    .num_y_in  (s1_py),
    .div       (t_used),
    .out_valid (d1_valid),
    .side_out  (d1_item),
    .quo_x     (d1_cx),
    .quo_y     (d1_cy),
    .rem_x     (d1_rx),
    .rem_y     (d1_ry)
  );

  // cell fraction (2r+1)/(2t) in q.16
  logic              d2_valid;
  cell_t             d1_cell;
  cell_t             d2_cell;
  logic [FRAC_W-1:0] d2_fx;
  logic [FRAC_W-1:0] d2_fy;

  assign d1_cell = '{item: d1_item, cx: d1_cx, cy: d1_cy};

  gnp_divider #(.NB(FRAC_W), .DW(TW + 1), .SW($bits(cell_t))) u_frac_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d1_valid),
    .side_in   (d1_cell),
    .rem_x_in  ({d1_rx, 1'b1}),
    .rem_y_in  ({d1_ry, 1'b1}),
    .num_x_in  ('0),
    .num_y_in  ('0),
    .div       ({t_used, 1'b0}),
    .out_valid (d2_valid),
    .side_out  (d2_cell),
    .quo_x     (d2_fx),
    .quo_y     (d2_fy),
    .rem_x     (),
    .rem_y     ()
  );

  // corner addresses and squared fractions
  logic [TABLE_AW-1:0] r0;
  logic [TABLE_AW-1:0] r1;
  logic [TABLE_AW-1:0] c0;
  logic                sa_valid;
  item_t               sa_item;
  logic [FRAC_W-1:0]   sa_fx;
  logic [FRAC_W-1:0]   sa_fy;
  logic [31:0]         sa_sqx;
  logic [31:0]         sa_sqy;
  logic [TABLE_AW-1:0] sa_a00;
  logic [TABLE_AW-1:0] sa_a01;
  logic [TABLE_AW-1:0] sa_a10;
  logic [TABLE_AW-1:0] sa_a11;

  assign r0 = TABLE_AW'(d2_cell.cy[TABLE_AW-1:0] * g_used);
  assign r1 = r0 + TABLE_AW'(g_used);
  assign c0 = d2_cell.cx[TABLE_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (en) begin
      sa_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_item <= d2_cell.item;
      sa_fx   <= d2_fx;
      sa_fy   <= d2_fy;
      sa_sqx  <= d2_fx * d2_fx;
      sa_sqy  <= d2_fy * d2_fy;
      sa_a00  <= r0 + c0;
      sa_a01  <= r1 + c0;
      sa_a10  <= r0 + c0 + TABLE_AW'(1);
      sa_a11  <= r1 + c0 + TABLE_AW'(1);
    end
  end

  // gradient table copies and smoothstep weights
  logic [31:0] tab00 [TABLE_DEPTH];
  logic [31:0] tab01 [TABLE_DEPTH];
  logic [31:0] tab10 [TABLE_DEPTH];
  logic [31:0] tab11 [TABLE_DEPTH];
  logic [31:0] wr_word;
  logic [49:0] wpx;
  logic [49:0] wpy;
  logic        sb_valid;
  item_t       sb_item;
  logic [FRAC_W-1:0] sb_fx;
  logic [FRAC_W-1:0] sb_fy;
  logic [FRAC_W-1:0] sb_wx;
  logic [FRAC_W-1:0] sb_wy;
  logic [31:0] sb_e00;
  logic [31:0] sb_e01;
  logic [31:0] sb_e10;
  logic [31:0] sb_e11;

  assign wr_word = {sa_item.gy, sa_item.gx};
  assign wpx = sa_sqx * (THREE_Q16 - {1'b0, sa_fx, 1'b0});
  assign wpy = sa_sqy * (THREE_Q16 - {1'b0, sa_fy, 1'b0});

  always_ff @(posedge clk) begin
    if (en && sa_valid && sa_item.cmd == CMD_LOAD) begin
      tab00[sa_item.idx] <= wr_word;
      tab01[sa_item.idx] <= wr_word;
      tab10[sa_item.idx] <= wr_word;
      tab11[sa_item.idx] <= wr_word;
    end
    if (en) begin
      sb_e00 <= tab00[sa_a00];
      sb_e01 <= tab01[sa_a01];
      sb_e10 <= tab10[sa_a10];
      sb_e11 <= tab11[sa_a11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (en) begin
      sb_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_item <= sa_item;
      sb_fx   <= sa_fx;
      sb_fy   <= sa_fy;
      sb_wx   <= wpx[47:32];
      sb_wy   <= wpy[47:32];
    end
  end

  // corner dot products
  logic signed [17:0] ox0;
  logic signed [17:0] ox1;
  logic signed [17:0] oy0;
  logic signed [17:0] oy1;
  logic               sc_valid;
  item_t              sc_item;
  logic [FRAC_W-1:0]  sc_wx;
  logic [FRAC_W-1:0]  sc_wy;
  logic signed [34:0] sc_d00;
  logic signed [34:0] sc_d01;
  logic signed [34:0] sc_d10;
  logic signed [34:0] sc_d11;

  assign ox0 = $signed({2'b00, sb_fx});
  assign oy0 = $signed({2'b00, sb_fy});
  assign ox1 = ox0 - ONE_Q16;
  assign oy1 = oy0 - ONE_Q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (en) begin
      sc_valid <= sb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_item <= sb_item;
      sc_wx   <= sb_wx;
      sc_wy   <= sb_wy;
      sc_d00  <= corner_dot(sb_e00, ox0, oy0);
      sc_d01  <= corner_dot(sb_e01, ox0, oy1);
      sc_d10  <= corner_dot(sb_e10, ox1, oy0);
      sc_d11  <= corner_dot(sb_e11, ox1, oy1);
    end
  end

  // vertical blend products
  logic signed [35:0] dl;
  logic signed [35:0] dr;
  logic signed [16:0] wys;
  logic               sd_valid;
  item_t              sd_item;
  logic [FRAC_W-1:0]  sd_wx;
  logic signed [34:0] sd_d00;
  logic signed [34:0] sd_d10;
  logic signed [52:0] sd_pl;
  logic signed [52:0] sd_pr;

  assign dl  = 36'(sc_d01) - 36'(sc_d00);
  assign dr  = 36'(sc_d11) - 36'(sc_d10);
  assign wys = $signed({1'b0, sc_wy});

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= 1'b0;
    end else if (en) begin
      sd_valid <= sc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_item <= sc_item;
      sd_wx   <= sc_wx;
      sd_d00  <= sc_d00;
      sd_d10  <= sc_d10;
      sd_pl   <= dl * wys;
      sd_pr   <= dr * wys;
    end
  end

  // vertical blend sums
  logic               se_valid;
  item_t              se_item;
  logic [FRAC_W-1:0]  se_wx;
  logic signed [37:0] se_left;
  logic signed [37:0] se_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      se_valid <= 1'b0;
    end else if (en) begin
      se_valid <= sd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_item  <= sd_item;
      se_wx    <= sd_wx;
      se_left  <= 38'(sd_d00) + 38'(sd_pl >>> 16);
      se_right <= 38'(sd_d10) + 38'(sd_pr >>> 16);
    end
  end

  // horizontal blend product
  logic signed [38:0] dh;
  logic signed [16:0] wxs;
  logic               sf_valid;
  item_t              sf_item;
  logic signed [37:0] sf_left;
  logic signed [55:0] sf_pt;

  assign dh  = 39'(se_right) - 39'(se_left);
  assign wxs = $signed({1'b0, se_wx});

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_valid <= 1'b0;
    end else if (en) begin
      sf_valid <= se_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf_item <= se_item;
      sf_left <= se_left;
      sf_pt   <= dh * wxs;
    end
  end

  // final sum, offset, saturation and output register
  logic signed [40:0] total;
  logic signed [40:0] vq;
  logic [15:0]        sat;

  assign total = 41'(sf_left) + 41'(sf_pt >>> 16);
  assign vq    = (total + HALF_Q30) >>> 14;

  always_comb begin
    priority if (vq < 0) begin
      sat = '0;
    end else if (vq > 41'sd65535) begin
      sat = 16'hFFFF;
    end else begin
      sat = vq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sf_valid && sf_item.cmd == CMD_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.noise_value <= sf_item.err ? 16'd0 : sat;
      out_data.coord_error <= sf_item.err;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.coord_error |-> out_data.noise_value == '0)
    else $error("flagged pixel with nonzero value");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(sf_valid) && $stable(se_valid) && $stable(out_data))
    else $error("pipeline moved during stall");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    en && sf_valid && sf_item.cmd == CMD_LOAD |=> !out_valid)
    else $error("load transaction produced a result");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !s0_valid)
    else $error("valid bits not cleared by reset");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the gradient noise pixel core.
//
// Loads gradient tables, evaluates pixels with random valid/ready gaps and
// checks each noise transaction against a predictor kept in the testbench.
// Pixels only touch corners that have been loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import gnp_pkg::*;

  localparam int LATENCY = 36;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst;
  logic wr_en;
  logic [REG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  gnp_stream_if #(.payload_t(pixel_req_t)) req ();
  gnp_stream_if #(.payload_t(pixel_rsp_t)) rsp ();

  gradient_noise_pixel_core u_dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .req(req), .rsp(rsp)
  );

  logic [31:0] grad_mem [TABLE_DEPTH];
  bit loaded [TABLE_DEPTH];
  int unsigned grid_reg;
  int unsigned tile_reg;
  pixel_rsp_t noise_q[$];
  int errors;
  int cycles;
  bit stall_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint grad_dot(int unsigned a, longint ox, longint oy);
    logic [31:0] e;
    longint gx, gy;
    e = grad_mem[a & 8'hff];
    gx = longint'($signed(e[15:0]));
    gy = longint'($signed(e[31:16]));
    return gx * ox + gy * oy;
  endfunction

  function automatic longint smoothstep_q16(longint t);
    return (t * t * (3 * 65536 - 2 * t)) >>> 32;
  endfunction

  function automatic longint lerp_q30(longint a, longint b, longint w);
    return a + floor_sh((b - a) * w, 16);
  endfunction

  function automatic int unsigned eff_grid();
    if (grid_reg < 2) return 2;
    if (grid_reg > 16) return 16;
    return grid_reg;
  endfunction

  function automatic int unsigned eff_tile();
    if (tile_reg < 1) return 1;
    if (tile_reg > 256) return 256;
    return tile_reg;
  endfunction

  function automatic pixel_rsp_t noise_predict(int unsigned px, int unsigned py);
    pixel_rsp_t r;
    int unsigned g, t, cx, cy, rx, ry;
    longint fx, fy, wx, wy, d1, d2, d3, d4, lt, rt, tot, v;
    g = eff_grid();
    t = eff_tile();
    r = '0;
    if (px >= (g - 1) * t || py >= (g - 1) * t) begin
      r.coord_error = 1'b1;
      return r;
    end
    cx = px / t; rx = px % t;
    cy = py / t; ry = py % t;
    fx = ((2 * longint'(rx) + 1) << 16) / (2 * t);
    fy = ((2 * longint'(ry) + 1) << 16) / (2 * t);
    d1 = grad_dot(cx + cy * g, fx, fy);
    d2 = grad_dot(cx + (cy + 1) * g, fx, fy - 65536);
    d3 = grad_dot(cx + 1 + cy * g, fx - 65536, fy);
    d4 = grad_dot(cx + 1 + (cy + 1) * g, fx - 65536, fy - 65536);
    wx = smoothstep_q16(fx);
    wy = smoothstep_q16(fy);
    lt = lerp_q30(d1, d2, wy);
    rt = lerp_q30(d3, d4, wy);
    tot = lerp_q30(lt, rt, wx);
    v = floor_sh(tot + (64'sd1 <<< 29), 14);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    r.noise_value = v[15:0];
    return r;
  endfunction

  // true when every corner this pixel would read has been loaded
  function automatic bit corners_loaded(int unsigned px, int unsigned py);
    int unsigned g, t, cx, cy;
    g = eff_grid();
    t = eff_tile();
    if (px >= (g - 1) * t || py >= (g - 1) * t) return 1'b1;
    cx = px / t;
    cy = py / t;
    return loaded[(cx + cy * g) & 8'hff] && loaded[(cx + (cy + 1) * g) & 8'hff]
        && loaded[(cx + 1 + cy * g) & 8'hff] && loaded[(cx + 1 + (cy + 1) * g) & 8'hff];
  endfunction

  task automatic send_item(pixel_req_t it);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.payload <= it;
    req.valid <= 1'b1;
    do @(posedge clk); while (!req.ready);
    if (it.command == CMD_LOAD) begin
      grad_mem[it.grid_index] = {it.grad_y, it.grad_x};
      loaded[it.grid_index] = 1'b1;
    end else begin
      noise_q.insert(noise_q.size(), noise_predict(it.pixel_x, it.pixel_y));
    end
  endtask

  task automatic load_grad(int unsigned idx, int gx, int gy);
    pixel_req_t it;
    it = '0;
    it.command = CMD_LOAD;
    it.grid_index = idx[7:0];
    it.grad_x = gx[15:0];
    it.grad_y = gy[15:0];
    send_item(it);
  endtask

  task automatic eval_pixel(int unsigned px, int unsigned py);
    pixel_req_t it;
    it = '0;
    it.command = CMD_PIXEL;
    it.pixel_x = px[11:0];
    it.pixel_y = py[11:0];
    it.grid_index = 8'($urandom());
    it.grad_x = 16'($urandom());
    it.grad_y = 16'($urandom());
    send_item(it);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_INDEX_W-1:0] idx, int unsigned val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    wr_en <= 1'b0;
    grid_reg = (idx == REG_GRID_SIZE) ? val & 5'h1f : grid_reg;
    tile_reg = (idx == REG_TILE_RES) ? val & 9'h1ff : tile_reg;
    @(posedge clk);
  endtask

  function automatic int rand_grad();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -16384;
    if (r == 1) return 16384;
    if (r == 2) return $signed(16'($urandom()));
    return $urandom_range(0, 32768) - 16384;
  endfunction

  task automatic load_all();
    for (int i = 0; i < TABLE_DEPTH; i++) load_grad(i, rand_grad(), rand_grad());
  endtask

  task automatic test_directed();
    int unsigned lim;
    load_grad(0, 16384, 16384);
    load_grad(1, -16384, 16384);
    load_grad(16, 16384, -16384);
    load_grad(17, -16384, -16384);
    load_grad(2, 32767, -32768);
    load_grad(18, -32768, 32767);
    load_grad(14, 16384, 0);
    load_grad(15, 0, -16384);
    load_grad(30, -16384, 0);
    load_grad(31, 0, 16384);
    lim = 15 * 16;
    eval_pixel(0, 0);
    eval_pixel(15, 15);
    eval_pixel(8, 7);
    eval_pixel(31, 0);
    eval_pixel(lim, 0);
    eval_pixel(0, lim);
    eval_pixel(4095, 4095);
    eval_pixel(lim - 1, 0);
    drain();
  endtask

  task automatic test_random_phase(int unsigned g, int unsigned t, int n);
    int unsigned lim, px, py;
    write_reg(REG_GRID_SIZE, g);
    write_reg(REG_TILE_RES, t);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        load_grad($urandom_range(0, 255), rand_grad(), rand_grad());
      end else begin
        lim = (eff_grid() - 1) * eff_tile();
        if ($urandom_range(0, 9) == 0) begin
          px = $urandom_range(0, 4095);
          py = $urandom_range(0, 4095);
        end else begin
          px = $urandom_range(0, lim - 1);
          py = $urandom_range(0, lim - 1);
        end
        if (corners_loaded(px, py)) eval_pixel(px, py);
      end
    end
    drain();
  endtask

  // response side: random ready and in-order compare
  initial begin
    pixel_rsp_t exp_r;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (!stall_off && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (noise_q.size() == 0) begin
          $error("unexpected transaction noise_value=%0d coord_error=%0b",
                 rsp.payload.noise_value, rsp.payload.coord_error);
          errors++;
        end else begin
          exp_r = noise_q.pop_front();
          if (rsp.payload.noise_value !== exp_r.noise_value) begin
            $error("noise_value exp %0d got %0d", exp_r.noise_value,
                   rsp.payload.noise_value);
            errors++;
          end
          if (rsp.payload.coord_error !== exp_r.coord_error) begin
            $error("coord_error exp %0b got %0b", exp_r.coord_error,
                   rsp.payload.coord_error);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    errors = 0;
    stall_off = 1'b0;
    grid_reg = 16;
    tile_reg = 16;
    for (int i = 0; i < TABLE_DEPTH; i++) loaded[i] = 1'b0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    req.valid = 1'b0;
    req.payload = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    load_all();
    drain();
    test_random_phase(16, 16, 300);
    test_random_phase(2, 1, 150);
    test_random_phase(0, 0, 100);
    test_random_phase(31, 511, 150);
    test_random_phase(16, 256, 250);
    stall_off = 1'b1;
    test_random_phase(7, 3, 250);
    stall_off = 1'b0;
    test_random_phase(11, 37, 250);
    test_random_phase(3, 200, 150);
    if (errors == 0 && noise_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
